// ===== hdl/cfws_pkg.sv =====
// cfws_pkg: shared types and constants of the circular fifo with search
// commands, status codes, controller states, result record and stream field layout
// no dependencies

package cfws_pkg;

	localparam int CMD_W       = 2;
	localparam int VAL_W       = 32;
	localparam int STATUS_W    = 2;
	localparam int SLOT_W      = 3;
	localparam int OCC_W       = 4;

	localparam int IN_TDATA_W  = 40;
	localparam int IN_CMD_LSB  = 0;
	localparam int IN_VAL_LSB  = IN_CMD_LSB + CMD_W;

	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_VOUT_LSB   = OUT_STATUS_LSB + STATUS_W;
	localparam int OUT_SLOT_LSB   = OUT_VOUT_LSB + VAL_W;
	localparam int OUT_OCC_LSB    = OUT_SLOT_LSB + SLOT_W;
	localparam int OUT_EMPTY_LSB  = OUT_OCC_LSB + OCC_W;
	localparam int OUT_FULL_LSB   = OUT_EMPTY_LSB + 1;
	localparam int OUT_HEAD_LSB   = OUT_FULL_LSB + 1;
	localparam int OUT_TAIL_LSB   = OUT_HEAD_LSB + VAL_W;
	localparam int OUT_USED_W     = OUT_TAIL_LSB + VAL_W;
	localparam int OUT_TDATA_W    = 112;
	localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ_CAP,
		S_SR_RD,
		S_SR_CMP,
		S_HT_RD,
		S_HT_CAP
	} state_e_t;

	typedef struct packed {
		status_e_t          status;
		logic [VAL_W-1:0]   value_out;
		logic [SLOT_W-1:0]  found_slot;
		logic [OCC_W-1:0]   occupancy;
		logic               is_empty;
		logic               is_full;
		logic [VAL_W-1:0]   head_value;
		logic [VAL_W-1:0]   tail_value;
	} result_t;

endpackage

// ===== hdl/cfws_ram.sv =====
// cfws_ram: generic ram, one write port and two read ports with registered read data
// no dependencies

module cfws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_a,
	output logic [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hdl/cfws_ctrl.sv =====
// cfws_ctrl: command sequencer, front and rear pointers, occupancy and search walk
// depends on cfws_pkg; drives the ports of one cfws_ram

module cfws_ctrl #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cfws_pkg::CMD_W-1:0]    in_cmd,
	input  logic [cfws_pkg::VAL_W-1:0]    in_val,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [DATA_WIDTH-1:0]         wr_data,
	output logic [AW-1:0]                 rd_addr_a,
	output logic [AW-1:0]                 rd_addr_b,
	input  logic [DATA_WIDTH-1:0]         rd_data_a,
	input  logic [DATA_WIDTH-1:0]         rd_data_b,
	input  logic                          out_free,
	output logic                          res_load,
	output cfws_pkg::result_t             res
);

	localparam int CW = $clog2(DEPTH + 1);

	cfws_pkg::state_e_t  state_q, state_nxt;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [AW-1:0]       pos_q;
	logic [CW-1:0]       scan_q;
	logic [cfws_pkg::CMD_W-1:0] cmd_q;
	logic [DATA_WIDTH-1:0]      val_q;
	cfws_pkg::status_e_t        status_q;
	logic [cfws_pkg::VAL_W-1:0] vout_q;
	logic [AW-1:0]              slot_q;
	logic                       empty;
	logic                       full;
	logic                       hit;
	logic                       scan_last;
	logic [AW-1:0]              tail_inc;

	function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign hit       = (rd_data_a == val_q);
	assign scan_last = ((scan_q + 1'b1) == count_q);
	assign tail_inc  = inc_idx(tail_q);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cfws_pkg::S_IDLE: begin
				if (in_valid) state_nxt = cfws_pkg::S_EXEC;
			end
			cfws_pkg::S_EXEC: begin
				case (cmd_q)
					cfws_pkg::CMD_DEQ:    state_nxt = empty ? cfws_pkg::S_HT_RD : cfws_pkg::S_DEQ_CAP;
					cfws_pkg::CMD_SEARCH: state_nxt = empty ? cfws_pkg::S_HT_RD : cfws_pkg::S_SR_RD;
					default:              state_nxt = cfws_pkg::S_HT_RD;
				endcase
			end
			cfws_pkg::S_DEQ_CAP: state_nxt = cfws_pkg::S_HT_RD;
			cfws_pkg::S_SR_RD:   state_nxt = cfws_pkg::S_SR_CMP;
			cfws_pkg::S_SR_CMP: begin
				state_nxt = (hit || scan_last) ? cfws_pkg::S_HT_RD : cfws_pkg::S_SR_RD;
			end
			cfws_pkg::S_HT_RD:   state_nxt = cfws_pkg::S_HT_CAP;
			cfws_pkg::S_HT_CAP: begin
				if (out_free) state_nxt = cfws_pkg::S_IDLE;
			end
			default: state_nxt = cfws_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == cfws_pkg::S_IDLE);
		wr_en     = (state_q == cfws_pkg::S_EXEC) && (cmd_q == cfws_pkg::CMD_ENQ) && !full;
		wr_addr   = tail_inc;
		wr_data   = val_q;
		rd_addr_a = (state_q == cfws_pkg::S_SR_RD) ? pos_q : head_q;
		rd_addr_b = tail_q;
		res_load  = (state_q == cfws_pkg::S_HT_CAP) && out_free;
	end

	always_comb begin
		res.status     = status_q;
		res.value_out  = vout_q;
		res.found_slot = cfws_pkg::SLOT_W'(slot_q);
		res.occupancy  = cfws_pkg::OCC_W'(count_q);
		res.is_empty   = empty;
		res.is_full    = full;
		res.head_value = empty ? '0 : cfws_pkg::VAL_W'(signed'(rd_data_a));
		res.tail_value = empty ? '0 : cfws_pkg::VAL_W'(signed'(rd_data_b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfws_pkg::S_IDLE;
			head_q  <= '0;
			tail_q  <= AW'(DEPTH - 1);
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				tail_q  <= tail_inc;
				count_q <= count_q + 1'b1;
			end
			if (state_q == cfws_pkg::S_DEQ_CAP) begin
				head_q  <= inc_idx(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload and search walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			cfws_pkg::S_IDLE: begin
				cmd_q <= in_cmd;
				val_q <= DATA_WIDTH'(in_val);
			end
			cfws_pkg::S_EXEC: begin
				status_q <= cfws_pkg::ST_OK;
				vout_q   <= '0;
				slot_q   <= '0;
				pos_q    <= head_q;
				scan_q   <= '0;
				case (cmd_q)
					cfws_pkg::CMD_ENQ: begin
						if (full) status_q <= cfws_pkg::ST_FULL;
					end
					cfws_pkg::CMD_DEQ: begin
						if (empty) status_q <= cfws_pkg::ST_EMPTY;
					end
					cfws_pkg::CMD_SEARCH: begin
						if (empty) status_q <= cfws_pkg::ST_NOT_FOUND;
					end
					default: ;
				endcase
			end
			cfws_pkg::S_DEQ_CAP: begin
				vout_q <= cfws_pkg::VAL_W'(signed'(rd_data_a));
			end
			cfws_pkg::S_SR_CMP: begin
				if (hit) begin
					slot_q <= pos_q;
				end else if (scan_last) begin
					status_q <= cfws_pkg::ST_NOT_FOUND;
				end else begin
					pos_q  <= inc_idx(pos_q);
					scan_q <= scan_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/circular_fifo_with_search.sv =====
// circular_fifo_with_search: ring-buffer queue with enqueue, dequeue and search commands
// depends on cfws_pkg, cfws_ram, cfws_ctrl
//
//   channel   dir  fields (lowest bit up)
//   s_axis    in   tdata: cmd[1:0], value_in[33:2], zero pad to 40 bits
//   m_axis    out  tdata: status, value_out, found_slot, occupancy, is_empty, is_full,
//                        head_value, tail_value, zero pad to 112 bits
//
// one command at a time: enqueue and no-op go through exec, head/tail read and capture;
// dequeue also captures the front value, search reads and compares entries up to a hit
// or the last one (neither when empty); the slot ram read is registered, once per compare
// reset sets state, pointers, occupancy and output valid; slot contents stay unknown until written
// a result waiting in the output register does not block the next input transfer;
// a stalled output holds the following result back in the controller

module circular_fifo_with_search #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [cfws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // cmd, value_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [cfws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // status .. tail_value
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [DATA_WIDTH-1:0]  wr_data;
	logic [AW-1:0]          rd_addr_a;
	logic [AW-1:0]          rd_addr_b;
	logic [DATA_WIDTH-1:0]  rd_data_a;
	logic [DATA_WIDTH-1:0]  rd_data_b;
	logic                   out_free;
	logic                   res_load;
	cfws_pkg::result_t      res;
	logic                   out_valid_q;
	logic [cfws_pkg::OUT_TDATA_W-1:0] out_data_q;

	cfws_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rd_data_a),
		.rdata_b (rd_data_b)
	);

	cfws_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tdata[cfws_pkg::IN_CMD_LSB +: cfws_pkg::CMD_W]),
		.in_val    (s_axis_tdata[cfws_pkg::IN_VAL_LSB +: cfws_pkg::VAL_W]),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= {{cfws_pkg::OUT_PAD_W{1'b0}}, res.tail_value, res.head_value,
			               res.is_full, res.is_empty, res.occupancy, res.found_slot,
			               res.value_out, res.status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/cfws_checker.sv =====
// cfws_checker: port-level checks of the circular fifo with search result stream
// depends on cfws_pkg; bound to circular_fifo_with_search

module cfws_checker #(
	parameter int DEPTH = 8
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [cfws_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [cfws_pkg::STATUS_W-1:0] status;
	logic [cfws_pkg::VAL_W-1:0]    value_out;
	logic [cfws_pkg::OCC_W-1:0]    occupancy;
	logic                          is_empty;
	logic                          is_full;
	logic [cfws_pkg::VAL_W-1:0]    head_value;
	logic [cfws_pkg::VAL_W-1:0]    tail_value;

	assign status     = m_axis_tdata[cfws_pkg::OUT_STATUS_LSB +: cfws_pkg::STATUS_W];
	assign value_out  = m_axis_tdata[cfws_pkg::OUT_VOUT_LSB +: cfws_pkg::VAL_W];
	assign occupancy  = m_axis_tdata[cfws_pkg::OUT_OCC_LSB +: cfws_pkg::OCC_W];
	assign is_empty   = m_axis_tdata[cfws_pkg::OUT_EMPTY_LSB];
	assign is_full    = m_axis_tdata[cfws_pkg::OUT_FULL_LSB];
	assign head_value = m_axis_tdata[cfws_pkg::OUT_HEAD_LSB +: cfws_pkg::VAL_W];
	assign tail_value = m_axis_tdata[cfws_pkg::OUT_TAIL_LSB +: cfws_pkg::VAL_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// empty queue reports zero occupancy, zero front and rear values and a clear full flag
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && is_empty |->
			occupancy == '0 && head_value == '0 && tail_value == '0 && !is_full)
		else $error("empty flag inconsistent with reported state");

	// full flag matches occupancy
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && is_full |-> occupancy == cfws_pkg::OCC_W'(DEPTH))
		else $error("full flag inconsistent with occupancy");

	// rejected commands agree with the flags and return no value
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (status == cfws_pkg::ST_FULL || status == cfws_pkg::ST_EMPTY) |->
			value_out == '0 &&
			(status == cfws_pkg::ST_FULL ? is_full : is_empty))
		else $error("rejected command inconsistent with flags");

endmodule

bind circular_fifo_with_search cfws_checker #(
	.DEPTH (DEPTH)
) u_cfws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/cfws_queue_checker.sv =====
// cfws_queue_checker: watches both stream channels of circular_fifo_with_search
// and keeps its own ring-buffer queue to predict each reply, then compares field by field
// depends on cfws_pkg

module cfws_queue_checker
	import cfws_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	input  logic                   s_ready,
	input  logic [IN_TDATA_W-1:0]  s_data,
	input  logic                   m_valid,
	input  logic                   m_ready,
	input  logic [OUT_TDATA_W-1:0] m_data,
	output int                     fail_count,
	output int                     outstanding
);

	localparam int DEPTH = 8;

	logic [VAL_W-1:0]  ring_slots [DEPTH];
	logic [SLOT_W-1:0] front_ptr;
	logic [SLOT_W-1:0] rear_ptr;
	logic [OCC_W-1:0]  held;
	result_t           queue_replies [$];
	result_t           seen_reply;
	result_t           want_reply;

	initial fail_count = 0;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
		return (int'(idx) == DEPTH - 1) ? '0 : idx + 1'b1;
	endfunction

	function automatic result_t apply_command(input logic [CMD_W-1:0] code,
			input logic [VAL_W-1:0] value);
		result_t           r;
		logic [SLOT_W-1:0] pos;
		logic              hit;
		r = '0;
		r.status = ST_OK;
		case (code)
			CMD_ENQ: begin
				if (int'(held) >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					rear_ptr = next_slot(rear_ptr);
					ring_slots[rear_ptr] = value;
					held = held + 1'b1;
				end
			end
			CMD_DEQ: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.value_out = ring_slots[front_ptr];
					front_ptr = next_slot(front_ptr);
					held = held - 1'b1;
				end
			end
			CMD_SEARCH: begin
				pos = front_ptr;
				hit = 1'b0;
				for (int n = 0; n < int'(held) && !hit; n++) begin
					if (ring_slots[pos] == value)
						hit = 1'b1;
					else
						pos = next_slot(pos);
				end
				if (hit)
					r.found_slot = pos;
				else
					r.status = ST_NOT_FOUND;
			end
			default: ;
		endcase
		r.occupancy  = held;
		r.is_empty   = (held == 0);
		r.is_full    = (int'(held) == DEPTH);
		r.head_value = (held != 0) ? ring_slots[front_ptr] : '0;
		r.tail_value = (held != 0) ? ring_slots[rear_ptr] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] seen,
			input logic [VAL_W-1:0] want);
		$display("mismatch on %s: got %h, expected %h", what, seen, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_ptr = '0;
			rear_ptr  = SLOT_W'(DEPTH - 1);
			held      = '0;
			queue_replies.delete();
			outstanding <= 0;
		end else begin
			if (s_valid && s_ready)
				queue_replies.push_back(apply_command(s_data[IN_CMD_LSB +: CMD_W],
					s_data[IN_VAL_LSB +: VAL_W]));
			if (m_valid && m_ready) begin
				seen_reply.status     = status_e_t'(m_data[OUT_STATUS_LSB +: STATUS_W]);
				seen_reply.value_out  = m_data[OUT_VOUT_LSB +: VAL_W];
				seen_reply.found_slot = m_data[OUT_SLOT_LSB +: SLOT_W];
				seen_reply.occupancy  = m_data[OUT_OCC_LSB +: OCC_W];
				seen_reply.is_empty   = m_data[OUT_EMPTY_LSB];
				seen_reply.is_full    = m_data[OUT_FULL_LSB];
				seen_reply.head_value = m_data[OUT_HEAD_LSB +: VAL_W];
				seen_reply.tail_value = m_data[OUT_TAIL_LSB +: VAL_W];
				if (queue_replies.size() == 0) begin
					report_mismatch("reply with none due", seen_reply.status, '0);
				end else begin
					want_reply = queue_replies.pop_front();
					if (seen_reply.status !== want_reply.status)
						report_mismatch("status", seen_reply.status, want_reply.status);
					if (seen_reply.value_out !== want_reply.value_out)
						report_mismatch("value_out", seen_reply.value_out,
							want_reply.value_out);
					if (seen_reply.found_slot !== want_reply.found_slot)
						report_mismatch("found_slot", seen_reply.found_slot,
							want_reply.found_slot);
					if (seen_reply.occupancy !== want_reply.occupancy)
						report_mismatch("occupancy", seen_reply.occupancy,
							want_reply.occupancy);
					if (seen_reply.is_empty !== want_reply.is_empty)
						report_mismatch("is_empty", seen_reply.is_empty,
							want_reply.is_empty);
					if (seen_reply.is_full !== want_reply.is_full)
						report_mismatch("is_full", seen_reply.is_full, want_reply.is_full);
					if (seen_reply.head_value !== want_reply.head_value)
						report_mismatch("head_value", seen_reply.head_value,
							want_reply.head_value);
					if (seen_reply.tail_value !== want_reply.tail_value)
						report_mismatch("tail_value", seen_reply.tail_value,
							want_reply.tail_value);
				end
			end
			outstanding <= queue_replies.size();
		end
	end

endmodule

// ===== verif/tb_circular_fifo_with_search.sv =====
// tb_circular_fifo_with_search: drives commands into circular_fifo_with_search, directed
// then random with sender gaps and receiver stalls; verdict by cfws_queue_checker, watchdog
// depends on cfws_pkg, cfws_queue_checker and the block under test

module tb_circular_fifo_with_search;
	import cfws_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int IN_PAD_W      = IN_TDATA_W - VAL_W - CMD_W;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 382;
	localparam int TX_IDLE [4]   = '{0, 45, 0, 13};
	localparam int RX_STALL [4]  = '{0, 0, 45, 13};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // cmd, value_in, zero pad
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status, value_out, found_slot, occupancy,
	                                        // is_empty, is_full, head_value, tail_value

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int fill_pct     = 50;
	int quiet_cycles = 0;
	int fail_count;
	int outstanding;

	logic [VAL_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'hffff_ffff, 32'h0000_0001, 32'h0000_0002, 32'haaaa_aaaa, 32'h5555_5555};

	circular_fifo_with_search #(
		.DEPTH      (8),
		.DATA_WIDTH (32)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cfws_queue_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_data      (s_axis_tdata),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// no transfer on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] code, input logic [VAL_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{IN_PAD_W{1'b0}}, value, code};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic random_command();
		int               roll;
		logic [CMD_W-1:0] code;
		logic [VAL_W-1:0] value;
		roll = $urandom_range(99);
		if (roll < 3)
			code = CMD_NOP;
		else if (roll < 30)
			code = CMD_SEARCH;
		else if ($urandom_range(99) < fill_pct)
			code = CMD_ENQ;
		else
			code = CMD_DEQ;
		// pool values give search hits and duplicates
		if ($urandom_range(1) == 1)
			value = value_pool[$urandom_range(7)];
		else
			value = $urandom();
		send_command(code, value);
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue
		send_command(CMD_SEARCH, 32'h0000_0000);
		send_command(CMD_DEQ, 32'h0000_0000);
		send_command(CMD_NOP, 32'hffff_ffff);
		// fill to full with extremes
		for (int i = 0; i < 8; i++)
			send_command(CMD_ENQ, value_pool[i]);
		send_command(CMD_ENQ, 32'h1234_5678);
		send_command(CMD_NOP, 32'h0000_0000);
		send_command(CMD_SEARCH, 32'h8000_0000);
		send_command(CMD_SEARCH, 32'h5555_5555);
		send_command(CMD_SEARCH, 32'h1234_5678);
		// wrap the pointers
		send_command(CMD_DEQ, 32'h0000_0000);
		send_command(CMD_DEQ, 32'h0000_0000);
		send_command(CMD_ENQ, 32'h8000_0000);
		send_command(CMD_ENQ, 32'h7fff_ffff);
		send_command(CMD_SEARCH, 32'h7fff_ffff);
		send_command(CMD_SEARCH, 32'h8000_0000);

		for (int ph = 0; ph < 4; ph++) begin
			hold_until_drained();
			tx_idle_pct  = TX_IDLE[ph];
			rx_stall_pct = RX_STALL[ph];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 16 == 0)
					fill_pct = 20 + 30 * $urandom_range(2);
				if ($urandom_range(199) == 0)
					hold_until_drained();
				random_command();
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/cfws_pkg.sv
hdl/cfws_ram.sv
hdl/cfws_ctrl.sv
hdl/circular_fifo_with_search.sv
hdl/cfws_checker.sv
verif/cfws_queue_checker.sv
verif/tb_circular_fifo_with_search.sv
